[rtl/cis_pkg.sv]
package cis_pkg;

    localparam int MAX_ENTRIES  = 256;
    localparam int PATTERN_BITS = 28;
    localparam int IDX_W        = $clog2(MAX_ENTRIES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int Q_W          = 17;
    localparam int CELLS        = IDX_W;

    localparam logic [Q_W-1:0]   ONE_Q16   = Q_W'(65536);
    localparam logic [Q_W-1:0]   GAP_LIMIT = Q_W'(33);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_ENTRIES);

    typedef enum logic [1:0] {
        ST_LOAD_OK   = 2'd0,
        ST_SAMPLE_OK = 2'd1,
        ST_NO_MATCH  = 2'd2,
        ST_GAP_ERR   = 2'd3
    } t_status;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        entry_index;
        logic [Q_W-1:0]          mass;
        logic [15:0]             category_id;
        logic [PATTERN_BITS-1:0] pattern;
        logic [Q_W-1:0]          uniform_value;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic [IDX_W-1:0]        ordinal;
        logic [15:0]             chosen_id;
        logic [PATTERN_BITS-1:0] chosen_pattern;
        logic [Q_W-1:0]          cumulative;
    } t_out_item;

    typedef struct packed {
        logic [Q_W-1:0]          cdf;
        logic [15:0]             id;
        logic [PATTERN_BITS-1:0] pattern;
    } t_entry;

    // search interval handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             probe;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] mid;
        logic [Q_W-1:0]   r;
    } t_tok;

    function automatic t_tok make_tok(logic v, logic [IDX_W-1:0] lo,
                                      logic [IDX_W-1:0] hi, logic [Q_W-1:0] r);
        t_tok t;
        t.valid = v;
        t.lo    = lo;
        t.hi    = hi;
        t.r     = r;
        t.probe = (lo < hi);
        t.mid   = lo + ((hi - lo) >> 1);
        return t;
    endfunction

    function automatic logic [IDX_W-1:0] tok_addr(t_tok t);
        return t.probe ? t.mid : t.lo;
    endfunction

endpackage

[rtl/cis_cell.sv]
module cis_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cis_pkg::t_tok             i_tok,
    input  logic [cis_pkg::Q_W-1:0]   i_rd_cdf,
    output cis_pkg::t_tok             o_tok,
    output logic [cis_pkg::IDX_W-1:0] o_addr
);
    import cis_pkg::*;

    t_tok             r_tok;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_comb begin
        lo = r_tok.lo;
        hi = r_tok.hi;
        if (r_tok.probe) begin
            if (r_tok.r > i_rd_cdf) begin
                lo = r_tok.mid + IDX_W'(1);
            end else begin
                hi = r_tok.mid;
            end
        end
        o_tok  = make_tok(r_tok.valid, lo, hi, r_tok.r);
        o_addr = tok_addr(o_tok);
    end

endmodule

[rtl/cdf_table_inverse_sampler_unit.sv]
// Channel   Ports                     Transfer
// --------  ------------------------  ---------------------------------
// item in   start, busy, i_item       start high and busy low at i_clk
// result    o_strobe, o_result        o_strobe high, one cycle, no stall
// config    i_cfg_we, i_cfg_wdata     i_cfg_we high at i_clk
//
// Load: one per cycle, result in the cycle after the transfer.
// Sample: an eight-cell search chain probes the single-read-port table once
// per cell, then one read of the found entry; the result strobe is registered after
// the cells and r_fin; busy stays high meanwhile, so no new sample or load is taken.
// Reset is synchronous, active low; table contents are not cleared.
// The receiver cannot stall; each result shows for exactly one cycle.
module cdf_table_inverse_sampler_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  cis_pkg::t_in_item         i_item,
    input  logic                      i_cfg_we,
    input  logic [cis_pkg::CNT_W-1:0] i_cfg_wdata,
    output logic                      o_strobe,
    output cis_pkg::t_out_item        o_result
);
    import cis_pkg::*;

    t_entry           r_mem [MAX_ENTRIES];
    t_entry           r_rd;
    logic [CNT_W-1:0] r_entries;
    logic [Q_W-1:0]   r_sum, n_sum;
    t_tok             r_fin;
    t_out_item        r_out, n_out;
    logic             r_strobe, n_strobe;

    t_tok             cell_in  [CELLS];
    t_tok             cell_out [CELLS];
    logic [IDX_W-1:0] cell_addr [CELLS];

    logic             accept, acc_load, acc_sample;
    logic [CNT_W-1:0] n_used;
    logic [IDX_W-1:0] last_idx;
    t_tok             tok0;
    logic [IDX_W-1:0] rd_addr;
    logic [Q_W:0]     sum_raw;
    logic [Q_W-1:0]   sum_ld;
    logic             gap_err;
    logic             chain_busy;

    assign accept     = start && !busy;
    assign acc_load   = accept && (i_item.op == OP_LOAD);
    assign acc_sample = accept && (i_item.op == OP_SAMPLE);

    always_comb begin
        if (r_entries == '0) begin
            n_used = CNT_W'(1);
        end else if (r_entries > CNT_MAX) begin
            n_used = CNT_MAX;
        end else begin
            n_used = r_entries;
        end
        last_idx = IDX_W'(n_used - CNT_W'(1));
        tok0     = make_tok(acc_sample, '0, last_idx, i_item.uniform_value);
    end

    // load path
    always_comb begin
        if (i_item.entry_index == '0) begin
            sum_raw = {1'b0, i_item.mass};
        end else begin
            sum_raw = {1'b0, r_sum} + {1'b0, i_item.mass};
        end
        sum_ld = (sum_raw > {1'b0, ONE_Q16}) ? ONE_Q16 : sum_raw[Q_W-1:0];
        gap_err = 1'b0;
        if (i_item.entry_index == last_idx) begin
            if ((ONE_Q16 - sum_ld) < GAP_LIMIT) begin
                sum_ld = ONE_Q16;
            end
            gap_err = (sum_ld != ONE_Q16);
        end
    end

    // search chain
    always_comb begin
        cell_in[0] = tok0;
        for (int k = 1; k < CELLS; k++) begin
            cell_in[k] = cell_out[k-1];
        end
    end

    generate
        for (genvar g = 0; g < CELLS; g++) begin : g_cell
            cis_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_tok    (cell_in[g]),
                .i_rd_cdf (r_rd.cdf),
                .o_tok    (cell_out[g]),
                .o_addr   (cell_addr[g])
            );
        end
    endgenerate

    always_comb begin
        rd_addr    = acc_sample ? tok_addr(tok0) : '0;
        chain_busy = r_fin.valid;
        for (int k = 0; k < CELLS; k++) begin
            rd_addr    = rd_addr | (cell_out[k].valid ? cell_addr[k] : '0);
            chain_busy = chain_busy | cell_out[k].valid;
        end
    end

    assign busy = chain_busy;

    always_ff @(posedge i_clk) begin
        if (acc_load) begin
            r_mem[i_item.entry_index] <= '{cdf: sum_ld, id: i_item.category_id,
                                           pattern: i_item.pattern};
        end
        r_rd <= r_mem[rd_addr];
    end

    // result
    always_comb begin
        n_strobe = 1'b0;
        n_sum    = r_sum;
        n_out    = r_out;
        if (acc_load) begin
            n_strobe             = 1'b1;
            n_sum                = sum_ld;
            n_out.status         = gap_err ? ST_GAP_ERR : ST_LOAD_OK;
            n_out.ordinal        = i_item.entry_index;
            n_out.chosen_id      = i_item.category_id;
            n_out.chosen_pattern = i_item.pattern;
            n_out.cumulative     = sum_ld;
        end else if (r_fin.valid) begin
            n_strobe = 1'b1;
            if (r_rd.cdf >= r_fin.r) begin
                n_out.status         = ST_SAMPLE_OK;
                n_out.ordinal        = r_fin.lo;
                n_out.chosen_id      = r_rd.id;
                n_out.chosen_pattern = r_rd.pattern;
                n_out.cumulative     = r_rd.cdf;
            end else begin
                n_out         = '0;
                n_out.status  = ST_NO_MATCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries   <= CNT_W'(1);
            r_sum       <= '0;
            r_strobe    <= 1'b0;
            r_fin.valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_entries <= i_cfg_wdata;
            end
            r_sum    <= n_sum;
            r_strobe <= n_strobe;
            r_fin    <= cell_out[CELLS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

[rtl/cis_checker.sv]
module cis_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input cis_pkg::t_in_item         i_item,
    input logic                      o_strobe,
    input cis_pkg::t_out_item        o_result
);
    import cis_pkg::*;

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.op == OP_SAMPLE |=> busy)
        else $error("sample transfer did not raise busy");

    a_sample_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.op == OP_SAMPLE |=> !o_strobe)
        else $error("result right after sample transfer");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.op == OP_LOAD |=>
            o_strobe && o_result.ordinal == $past(i_item.entry_index)
            && (o_result.status == ST_LOAD_OK || o_result.status == ST_GAP_ERR))
        else $error("load result missing or wrong");

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status == ST_NO_MATCH |->
            o_result.ordinal == '0 && o_result.cumulative == '0
            && o_result.chosen_id == '0 && o_result.chosen_pattern == '0)
        else $error("no-match result carries data");

endmodule

bind cdf_table_inverse_sampler_unit cis_checker u_cis_checker (.*);

[tb/sv/cdf_sampler_tb_pkg.sv]
`timescale 1ns / 100ps

package cdf_sampler_tb_pkg;

    import cis_pkg::*;

    class draw_table_model;

        logic [Q_W-1:0]          cdf_mem [MAX_ENTRIES];
        logic [15:0]             id_mem  [MAX_ENTRIES];
        logic [PATTERN_BITS-1:0] pat_mem [MAX_ENTRIES];
        bit                      loaded  [MAX_ENTRIES];
        logic [Q_W-1:0]          run_sum;
        logic [CNT_W-1:0]        size_reg;
        t_out_item               expected_q [$];

        int mismatches;
        int loads;
        int gap_errs;
        int draws;
        int hits;
        int misses;

        function new();
            foreach (cdf_mem[i]) begin
                cdf_mem[i] = '0;
                id_mem[i]  = '0;
                pat_mem[i] = '0;
                loaded[i]  = 1'b0;
            end
            run_sum  = '0;
            size_reg = CNT_W'(1);
        endfunction

        function void set_size(logic [CNT_W-1:0] v);
            size_reg = v;
        endfunction

        function int table_len();
            int n;
            n = size_reg;
            if (n == 0) n = 1;
            if (n > MAX_ENTRIES) n = MAX_ENTRIES;
            return n;
        endfunction

        // true when a search over n entries only touches loaded entries
        function bit covers(int n);
            for (int i = 0; i < n; i++) begin
                if (!loaded[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task note_transfer(t_in_item it);
            t_out_item   res;
            int unsigned acc;
            int          n;
            int          lo;
            int          hi;
            int          mid;
            int          idx;

            n   = table_len();
            res = '0;
            if (it.op == OP_LOAD) begin
                idx = it.entry_index;
                acc = (idx == 0) ? it.mass : run_sum + it.mass;
                if (acc > ONE_Q16) acc = ONE_Q16;
                res.status = ST_LOAD_OK;
                if (idx == n - 1) begin
                    if (ONE_Q16 - acc < GAP_LIMIT) acc = ONE_Q16;
                    if (acc != ONE_Q16) res.status = ST_GAP_ERR;
                end
                run_sum      = Q_W'(acc);
                cdf_mem[idx] = Q_W'(acc);
                id_mem[idx]  = it.category_id;
                pat_mem[idx] = it.pattern;
                loaded[idx]  = 1'b1;
                res.ordinal        = it.entry_index;
                res.chosen_id      = it.category_id;
                res.chosen_pattern = it.pattern;
                res.cumulative     = Q_W'(acc);
                loads++;
                if (res.status == ST_GAP_ERR) gap_errs++;
            end else begin
                lo = 0;
                hi = n - 1;
                while (lo < hi) begin
                    mid = lo + ((hi - lo) >> 1);
                    if (it.uniform_value > cdf_mem[mid]) lo = mid + 1;
                    else hi = mid;
                end
                if (cdf_mem[lo] >= it.uniform_value) begin
                    res.status         = ST_SAMPLE_OK;
                    res.ordinal        = IDX_W'(lo);
                    res.chosen_id      = id_mem[lo];
                    res.chosen_pattern = pat_mem[lo];
                    res.cumulative     = cdf_mem[lo];
                    hits++;
                end else begin
                    res.status = ST_NO_MATCH;
                    misses++;
                end
                draws++;
            end
            expected_q.push_back(res);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result: status %0d ordinal %0d",
                                          got.status, got.ordinal));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.ordinal !== want.ordinal)
                report_mismatch($sformatf("ordinal %0d, want %0d",
                                          got.ordinal, want.ordinal));
            if (got.chosen_id !== want.chosen_id)
                report_mismatch($sformatf("chosen_id %h, want %h",
                                          got.chosen_id, want.chosen_id));
            if (got.chosen_pattern !== want.chosen_pattern)
                report_mismatch($sformatf("chosen_pattern %h, want %h",
                                          got.chosen_pattern, want.chosen_pattern));
            if (got.cumulative !== want.cumulative)
                report_mismatch($sformatf("cumulative %0d, want %0d",
                                          got.cumulative, want.cumulative));
        endtask

    endclass

endpackage

[tb/sv/cdf_table_inverse_sampler_unit_tb.sv]
`timescale 1ns / 100ps

module cdf_table_inverse_sampler_unit_tb;

    import cis_pkg::*;
    import cdf_sampler_tb_pkg::*;

    localparam int ITEM_TARGET = 850;
    localparam int Q_MAX       = (1 << Q_W) - 1;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_in_item           i_item;
    logic               i_cfg_we;
    logic [CNT_W-1:0]   i_cfg_wdata;
    logic               o_strobe;
    t_out_item          o_result;

    draw_table_model tracker = new();

    int items_sent;
    int cfg_writes;
    bit no_idle;

    cdf_table_inverse_sampler_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) tracker.check_result(o_result);
    end

    function automatic int pick_gap();
        int sel;
        if (no_idle) return 0;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 88) return $urandom_range(1, 3);
        if (sel < 97) return $urandom_range(4, 9);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item make_load(int idx, int mass);
        t_in_item it;
        it.op            = OP_LOAD;
        it.entry_index   = IDX_W'(idx);
        it.mass          = Q_W'(mass);
        it.category_id   = 16'($urandom);
        it.pattern       = PATTERN_BITS'($urandom);
        it.uniform_value = Q_W'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_draw(int r);
        t_in_item it;
        it.op            = OP_SAMPLE;
        it.entry_index   = IDX_W'($urandom);
        it.mass          = Q_W'($urandom);
        it.category_id   = 16'($urandom);
        it.pattern       = PATTERN_BITS'($urandom);
        it.uniform_value = Q_W'(r);
        return it;
    endfunction

    // r uniform up to 1.0, near stored boundaries, at the ends of the range or above 1.0
    function automatic int pick_r(int n);
        int sel;
        int r;
        sel = $urandom_range(0, 99);
        if (sel < 45) return $urandom_range(0, ONE_Q16);
        if (sel < 75) begin
            r = tracker.cdf_mem[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1;
            if (r < 0) r = 0;
            return r;
        end
        if (sel < 82) return 0;
        if (sel < 88) return ONE_Q16;
        return $urandom_range(ONE_Q16 + 1, Q_MAX);
    endfunction

    task automatic send(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.note_transfer(it);
        items_sent++;
    endtask

    task automatic finish_phase();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_size(input int v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CNT_W'(v);
        @(posedge i_clk);
        tracker.set_size(CNT_W'(v));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // well-formed table: masses split 1.0, last entry lands exact, close, short or over
    task automatic load_table(input int n);
        int rem;
        int m;
        int sel;
        rem = ONE_Q16;
        for (int i = 0; i < n - 1; i++) begin
            if ($urandom_range(0, 6) == 0) m = 0;
            else m = $urandom_range(0, 2 * rem / (n - i));
            send(make_load(i, m));
            rem -= m;
        end
        sel = $urandom_range(0, 99);
        m   = rem;
        if (sel >= 55 && sel < 70) m = rem - $urandom_range(1, 32);
        else if (sel >= 70 && sel < 85) m = rem - $urandom_range(33, 3000);
        else if (sel >= 85) m = rem + $urandom_range(1, 70000);
        if (m < 0) m = 0;
        if (m > Q_MAX) m = Q_MAX;
        send(make_load(n - 1, m));
    endtask

    task automatic directed_checks();
        t_in_item it;
        // single entry table after reset
        it = make_load(0, ONE_Q16);
        it.category_id = '1;
        it.pattern     = '1;
        send(it);
        send(make_draw(0));
        send(make_draw(ONE_Q16));
        send(make_draw(ONE_Q16 + 1));
        send(make_draw(Q_MAX));
        send(make_load(0, ONE_Q16 - 32));
        send(make_load(0, ONE_Q16 - 33));
        send(make_draw(ONE_Q16 - 33));
        send(make_draw(ONE_Q16 - 32));
        it = make_load(0, Q_MAX);
        it.category_id = '0;
        it.pattern     = '0;
        send(it);
        send(make_load(5, 100));
        finish_phase();
        write_size(2);
        send(make_load(0, 0));
        send(make_load(1, ONE_Q16));
        send(make_draw(0));
        send(make_draw(1));
        send(make_load(1, 40000));
        send(make_draw(ONE_Q16));
        finish_phase();
        // zero size behaves as one entry
        write_size(0);
        send(make_load(0, 30000));
        send(make_draw(30000));
        send(make_draw(30001));
        finish_phase();
    endtask

    initial begin
        int  v;
        int  n;
        int  k;
        int  sel;
        int  phase;
        int  cnt;
        bit  did_max_cfg;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        items_sent  = 0;
        cfg_writes  = 0;
        no_idle     = 1'b0;
        phase       = 0;
        did_max_cfg = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_checks();

        while (items_sent < ITEM_TARGET) begin
            phase++;
            no_idle = ($urandom_range(0, 3) == 0);
            sel     = $urandom_range(0, 99);
            if (phase == 1) v = MAX_ENTRIES;
            else if (!did_max_cfg && items_sent > 450) v = (1 << CNT_W) - 1;
            else if (sel < 5) v = 0;
            else if (sel < 10) v = 1;
            else if (sel < 78) v = $urandom_range(2, 16);
            else if (sel < 92) v = $urandom_range(17, 48);
            else v = $urandom_range(MAX_ENTRIES + 1, (1 << CNT_W) - 1);
            if (v == (1 << CNT_W) - 1) did_max_cfg = 1'b1;
            write_size(v);
            n = tracker.table_len();

            if (n == MAX_ENTRIES && phase != 1) begin
                // reload only the tail; the sum carries on from what it holds
                k = $urandom_range(200, MAX_ENTRIES - 1);
                for (int i = k; i < MAX_ENTRIES; i++) begin
                    send(make_load(i, $urandom_range(0, 700)));
                end
            end else begin
                load_table(n);
                if ($urandom_range(0, 6) == 0) begin
                    cnt = $urandom_range(1, 4);
                    repeat (cnt) begin
                        send(make_load($urandom_range(0, MAX_ENTRIES - 1),
                                       $urandom_range(0, Q_MAX)));
                    end
                end
            end

            if (tracker.covers(n)) begin
                cnt = (n == MAX_ENTRIES) ? 30 : $urandom_range(4, 24);
                repeat (cnt) send(make_draw(pick_r(n)));
            end
            finish_phase();
        end

        repeat (20) @(posedge i_clk);
        if (tracker.pending() != 0)
            tracker.report_mismatch($sformatf("%0d results never arrived",
                                              tracker.pending()));

        $display("Covered %0d loads (%0d with final-gap error) and %0d draws",
                 tracker.loads, tracker.gap_errs, tracker.draws);
        $display("Draws found %0d, no match %0d; %0d size settings written",
                 tracker.hits, tracker.misses, cfg_writes);
        if (tracker.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
